@@ rtl/psds_pkg.sv @@
// ----------------------------------------------------------------------------
// psds_pkg - shared types and constants for the parity split double stack
// Sizes of the shared store and levels, operation and status codes, the
// controller state type and the command and status bundles.
// ----------------------------------------------------------------------------
package psds_pkg;

    // store geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LVL_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;

    // operation codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PUSH      = 2'd0;
    localparam t_kind KIND_POP_LOWER = 2'd1;
    localparam t_kind KIND_POP_UPPER = 2'd2;

    // status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LVL_W-1:0]  t_level;
    typedef logic [ADDR_W-1:0] t_addr;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;   // take the input word, update levels and store
        logic fetch;    // reload a top cache from the store read data
        logic emit;     // load the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_go;   // offered word is a pop of a non-empty stack
    } t_ctrl_sts;

endpackage

@@ rtl/psds_if.sv @@
// ----------------------------------------------------------------------------
// psds_in_if / psds_out_if - valid/ready channels of the double stack
// One interface for the operation words, one for the result words.
// ----------------------------------------------------------------------------
interface psds_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic signed [31:0]      value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface psds_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      popped_value;
    logic [1:0]              status;
    logic signed [31:0]      lower_top_value;
    logic                    lower_empty;
    logic signed [31:0]      upper_top_value;
    logic                    upper_empty;
    logic [4:0]              lower_count;
    logic [4:0]              upper_count;

    modport source (
        output valid, output popped_value, output status,
        output lower_top_value, output lower_empty,
        output upper_top_value, output upper_empty,
        output lower_count, output upper_count,
        input  ready
    );
    modport sink (
        input  valid, input popped_value, input status,
        input  lower_top_value, input lower_empty,
        input  upper_top_value, input upper_empty,
        input  lower_count, input upper_count,
        output ready
    );
endinterface

@@ rtl/psds_ram.sv @@
// ----------------------------------------------------------------------------
// psds_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/psds_ctrl.sv @@
// ----------------------------------------------------------------------------
// psds_ctrl - sequencer for the double stack
// Takes one word at a time, waits for the store read after a pop of a
// non-empty stack and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module psds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  psds_pkg::t_ctrl_sts i_sts,
    output psds_pkg::t_ctrl_cmd o_cmd
);
    import psds_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.pop_go ? S_FETCH : S_RESULT;
                end
            end
            S_FETCH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.fetch  = 1'b0;
        o_cmd.emit   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            S_RESULT: begin
                o_cmd.emit = slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // output word valid flag
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a stalled result word is never dropped
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result word lost under stall");

    // a successful pop always passes through the fetch state
    a_pop_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_sts.pop_go |=> r_state == S_FETCH)
        else $error("pop accepted without store fetch");
endmodule

@@ rtl/psds_dp.sv @@
// ----------------------------------------------------------------------------
// psds_dp - datapath of the double stack
// Levels, cached top words, the shared store and the output register.
// ----------------------------------------------------------------------------
module psds_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  psds_pkg::t_kind            i_kind,
    input  psds_pkg::t_word            i_value,
    input  psds_pkg::t_ctrl_cmd        i_cmd,
    output psds_pkg::t_ctrl_sts        o_sts,
    output psds_pkg::t_word            o_popped_value,
    output psds_pkg::t_status          o_status,
    output psds_pkg::t_word            o_lower_top_value,
    output logic                       o_lower_empty,
    output psds_pkg::t_word            o_upper_top_value,
    output logic                       o_upper_empty,
    output logic [psds_pkg::COUNT_W-1:0] o_lower_count,
    output logic [psds_pkg::COUNT_W-1:0] o_upper_count
);
    import psds_pkg::*;

    t_level  r_lower_level;
    t_level  r_upper_level;
    t_word   r_lower_top;
    t_word   r_upper_top;
    t_word   r_popped;
    t_status r_status;
    logic    r_fix_lower;

    t_word   r_out_popped;
    t_status r_out_status;
    t_word   r_out_lower_top;
    logic    r_out_lower_empty;
    t_word   r_out_upper_top;
    logic    r_out_upper_empty;
    logic [COUNT_W-1:0] r_out_lower_count;
    logic [COUNT_W-1:0] r_out_upper_count;

    logic    full;
    logic    lower_empty;
    logic    upper_empty;
    logic    push_ok;
    logic    we;
    t_addr   waddr;
    t_addr   raddr;
    t_word   rdata;
    logic [LVL_W:0] used;

    assign used        = {1'b0, r_lower_level} + {1'b0, r_upper_level};
    assign full        = used >= (LVL_W + 1)'(DEPTH);
    assign lower_empty = r_lower_level == '0;
    assign upper_empty = r_upper_level == '0;
    assign push_ok     = i_kind == KIND_PUSH && !full;

    assign o_sts.pop_go = (i_kind == KIND_POP_LOWER && !lower_empty) ||
                          (i_kind == KIND_POP_UPPER && !upper_empty);

    // store ports: even words at the lower level, odd ones just below the upper
    assign we    = i_cmd.accept && push_ok;
    assign waddr = i_value[0] ? ADDR_W'(t_level'(DEPTH - 1) - r_upper_level)
                              : ADDR_W'(r_lower_level);
    // new top after a pop: lower at level-2, upper at DEPTH-level+1
    assign raddr = (i_kind == KIND_POP_LOWER)
                 ? ADDR_W'(r_lower_level - t_level'(2))
                 : ADDR_W'(t_level'(DEPTH + 1) - r_upper_level);

    psds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_level <= '0;
            r_upper_level <= '0;
        end else if (i_cmd.accept) begin
            case (i_kind)
                KIND_PUSH: begin
                    if (!full) begin
                        if (i_value[0]) begin
                            r_upper_level <= r_upper_level + t_level'(1);
                        end else begin
                            r_lower_level <= r_lower_level + t_level'(1);
                        end
                    end
                end
                KIND_POP_LOWER: begin
                    if (!lower_empty) begin
                        r_lower_level <= r_lower_level - t_level'(1);
                    end
                end
                KIND_POP_UPPER: begin
                    if (!upper_empty) begin
                        r_upper_level <= r_upper_level - t_level'(1);
                    end
                end
                default: begin
                    r_lower_level <= r_lower_level;
                end
            endcase
        end
    end

    // top caches, popped word and step status
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_popped    <= '0;
            r_status    <= ST_OK;
            r_fix_lower <= i_kind == KIND_POP_LOWER;
            case (i_kind)
                KIND_PUSH: begin
                    if (full) begin
                        r_status <= ST_FULL;
                    end else if (i_value[0]) begin
                        r_upper_top <= i_value;
                    end else begin
                        r_lower_top <= i_value;
                    end
                end
                KIND_POP_LOWER: begin
                    if (lower_empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_popped <= r_lower_top;
                    end
                end
                KIND_POP_UPPER: begin
                    if (upper_empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_popped <= r_upper_top;
                    end
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end else if (i_cmd.fetch) begin
            if (r_fix_lower) begin
                r_lower_top <= rdata;
            end else begin
                r_upper_top <= rdata;
            end
        end
    end

    // output register; an empty stack shows a zero top
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_popped      <= r_popped;
            r_out_status      <= r_status;
            r_out_lower_top   <= lower_empty ? '0 : r_lower_top;
            r_out_lower_empty <= lower_empty;
            r_out_upper_top   <= upper_empty ? '0 : r_upper_top;
            r_out_upper_empty <= upper_empty;
            r_out_lower_count <= COUNT_W'(r_lower_level);
            r_out_upper_count <= COUNT_W'(r_upper_level);
        end
    end

    assign o_popped_value    = r_out_popped;
    assign o_status          = r_out_status;
    assign o_lower_top_value = r_out_lower_top;
    assign o_lower_empty     = r_out_lower_empty;
    assign o_upper_top_value = r_out_upper_top;
    assign o_upper_empty     = r_out_upper_empty;
    assign o_lower_count     = r_out_lower_count;
    assign o_upper_count     = r_out_upper_count;

    // the two stacks never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used <= (LVL_W + 1)'(DEPTH))
        else $error("stacks overlap");

    // a refused push leaves both levels as they were
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && i_kind == KIND_PUSH && full |=>
            $stable(r_lower_level) && $stable(r_upper_level) && r_status == ST_FULL)
        else $error("refused push changed a level");

    // a pop of an empty stack reports empty and pops nothing
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && ((i_kind == KIND_POP_LOWER && lower_empty) ||
                         (i_kind == KIND_POP_UPPER && upper_empty)) |=>
            r_status == ST_EMPTY && r_popped == '0)
        else $error("empty pop misreported");
endmodule

@@ rtl/parity_split_double_stack_core.sv @@
// ----------------------------------------------------------------------------
// parity_split_double_stack_core - two stacks in one shared store
// Usage:
//   i_cmd carries operation words (kind, value) on a valid/ready channel;
//   kind 0 pushes value (even words to the lower stack, odd words to the
//   upper stack), kind 1 pops the lower stack, kind 2 pops the upper stack.
//   o_res carries one result word per operation: popped value, status
//   (ok, full, empty) and both tops, empty flags and counts after the step.
// Flow:
//   The block takes one operation at a time. A push, a refused or empty
//   pop and the unused kind go from acceptance straight to the result
//   state; a successful pop passes first through a fetch state, the
//   registered read of the shared store that fetches the new top.
//   A new operation is taken only once the last result is in the output register.
// Reset:
//   Synchronous, active low; both stacks are emptied at once. The store
//   itself is not cleared: words outside a stack never reach the result.
// Stall:
//   The result sits in an output register until taken; the block finishes
//   the next operation meanwhile and then waits for that register to free.
// ----------------------------------------------------------------------------
module parity_split_double_stack_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    psds_in_if.sink          i_cmd,
    psds_out_if.source       o_res
);
    import psds_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;
    logic      in_ready;
    logic      out_valid;

    psds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (ctrl_sts),
        .o_cmd       (ctrl_cmd)
    );

    psds_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_kind            (i_cmd.kind),
        .i_value           (i_cmd.value),
        .i_cmd             (ctrl_cmd),
        .o_sts             (ctrl_sts),
        .o_popped_value    (o_res.popped_value),
        .o_status          (o_res.status),
        .o_lower_top_value (o_res.lower_top_value),
        .o_lower_empty     (o_res.lower_empty),
        .o_upper_top_value (o_res.upper_top_value),
        .o_upper_empty     (o_res.upper_empty),
        .o_lower_count     (o_res.lower_count),
        .o_upper_count     (o_res.upper_count)
    );

    assign i_cmd.ready = in_ready;
    assign o_res.valid = out_valid;
endmodule

@@ tb/parity_split_double_stack_core_test.sv @@
// ----------------------------------------------------------------------------
// parity_split_double_stack_core_test - self-checking bench for the core
// Drives operation words (push, pop lower, pop upper, unused kind) through the
// command channel with random gaps. A scoreboard class mirrors both stacks,
// predicts every result word and compares it field by field with the output.
// ----------------------------------------------------------------------------
module parity_split_double_stack_core_test;
    import psds_pkg::*;

    // expected contents of one result word
    typedef struct packed {
        t_word                popped_value;
        t_status              status;
        t_word                lower_top_value;
        logic                 lower_empty;
        t_word                upper_top_value;
        logic                 upper_empty;
        logic [COUNT_W-1:0]   lower_count;
        logic [COUNT_W-1:0]   upper_count;
    } t_stack_result;

    // mirror of the two stacks plus the queue of results still due
    class stack_pair_tracker;
        t_word          store [DEPTH];
        int             lower_level;
        int             upper_level;
        t_stack_result  pending [$];
        int             mismatches;

        function new();
            foreach (store[i]) store[i] = '0;
            lower_level = 0;
            upper_level = 0;
            mismatches  = 0;
        endfunction

        // apply one accepted operation word and queue its result
        function void note_word(t_kind kind, t_word value);
            t_stack_result r;
            r = '0;
            r.status = ST_OK;
            case (kind)
                KIND_PUSH: begin
                    if (lower_level + upper_level >= DEPTH) begin
                        r.status = ST_FULL;
                    end else if (!value[0]) begin
                        store[lower_level] = value;
                        lower_level++;
                    end else begin
                        upper_level++;
                        store[DEPTH - upper_level] = value;
                    end
                end
                KIND_POP_LOWER: begin
                    if (lower_level == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped_value = store[lower_level - 1];
                        lower_level--;
                    end
                end
                KIND_POP_UPPER: begin
                    if (upper_level == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped_value = store[DEPTH - upper_level];
                        upper_level--;
                    end
                end
                default: ;  // unused kind: stacks untouched
            endcase
            r.lower_top_value = (lower_level != 0) ? store[lower_level - 1] : '0;
            r.upper_top_value = (upper_level != 0) ? store[DEPTH - upper_level] : '0;
            r.lower_empty     = (lower_level == 0);
            r.upper_empty     = (upper_level == 0);
            r.lower_count     = COUNT_W'(lower_level);
            r.upper_count     = COUNT_W'(upper_level);
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h actual %0h", name, want, seen);
                mismatches++;
            end
        endfunction

        // compare one taken result word with the oldest prediction
        function void check_result(t_stack_result got);
            t_stack_result want;
            if (pending.size() == 0) begin
                $error("result word with no operation outstanding");
                mismatches++;
                return;
            end
            want = pending.pop_front();
            check_field("popped_value",    want.popped_value,    got.popped_value);
            check_field("status",          want.status,          got.status);
            check_field("lower_top_value", want.lower_top_value, got.lower_top_value);
            check_field("lower_empty",     want.lower_empty,     got.lower_empty);
            check_field("upper_top_value", want.upper_top_value, got.upper_top_value);
            check_field("upper_empty",     want.upper_empty,     got.upper_empty);
            check_field("lower_count",     want.lower_count,     got.lower_count);
            check_field("upper_count",     want.upper_count,     got.upper_count);
        endfunction
    endclass

    localparam t_kind KIND_NOP     = 2'd3;
    localparam int    RANDOM_WORDS = 700;
    localparam int    TAIL_START   = 600;   // no idling from here on

    logic           i_clk;
    logic           i_rst_n;
    bit             steady_tail;
    t_stack_result  seen_result;

    stack_pair_tracker tracker = new();

    psds_in_if  cmd_if ();
    psds_out_if res_if ();

    parity_split_double_stack_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // present one operation word, optionally after a gap, until it is taken
    task automatic send_word(t_kind kind, t_word value);
        int gap;
        gap = (!steady_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.kind  <= kind;
        cmd_if.value <= value;
        do @(posedge i_clk); while (!cmd_if.ready);
        tracker.note_word(kind, value);
    endtask

    // receiver: ready held low in random bursts, steady in the tail
    initial begin
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (!steady_tail && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat (steady_tail ? 1 : $urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_result.popped_value    = res_if.popped_value;
            seen_result.status          = res_if.status;
            seen_result.lower_top_value = res_if.lower_top_value;
            seen_result.lower_empty     = res_if.lower_empty;
            seen_result.upper_top_value = res_if.upper_top_value;
            seen_result.upper_empty     = res_if.upper_empty;
            seen_result.lower_count     = res_if.lower_count;
            seen_result.upper_count     = res_if.upper_count;
            tracker.check_result(seen_result);
        end
    end

    // stimulus
    initial begin
        t_kind kind;
        t_word value;
        int    mode;
        int    push_pct;

        i_rst_n      = 1'b0;
        steady_tail  = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.kind  = KIND_PUSH;
        cmd_if.value = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pops and the unused kind on empty stacks
        send_word(KIND_POP_LOWER, 32'h1234_5678);
        send_word(KIND_POP_UPPER, 32'hFFFF_FFFF);
        send_word(KIND_NOP, 32'hFFFF_FFFF);

        // extreme words, both parities
        send_word(KIND_PUSH, 32'h8000_0000);
        send_word(KIND_PUSH, 32'h7FFF_FFFF);
        send_word(KIND_PUSH, 32'h0000_0000);
        send_word(KIND_PUSH, 32'hFFFF_FFFF);

        // fill the store to the last entry, then a refused push
        for (int i = 0; i < DEPTH - 4; i++)
            send_word(KIND_PUSH, {31'($urandom()), i[0]});
        send_word(KIND_PUSH, $urandom());
        send_word(KIND_POP_UPPER, '0);
        send_word(KIND_POP_LOWER, '0);
        send_word(KIND_NOP, 32'h5555_5555);

        // random words in phases that lean towards filling or draining
        mode = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == TAIL_START)
                steady_tail = 1'b1;
            if (n % 32 == 0)
                mode = $urandom_range(0, 2);
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;

            if ($urandom_range(0, 99) < 4)
                kind = KIND_NOP;
            else if ($urandom_range(0, 99) < push_pct)
                kind = KIND_PUSH;
            else
                kind = $urandom_range(0, 1) ? KIND_POP_LOWER : KIND_POP_UPPER;

            case ($urandom_range(0, 15))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'hFFFF_FFFF;
                3:       value = $urandom_range(0, 1);
                default: value = $urandom();
            endcase
            send_word(kind, value);
        end
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("[parity_split_double_stack_core] OK");
        else
            $display("[parity_split_double_stack_core] ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("[parity_split_double_stack_core] ERROR");
        $finish;
    end

endmodule
